@@ sv/wpc_pkg.sv @@
package wpc_pkg;

  localparam logic [31:0] CRC_REFL_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFFFFFF;
  localparam logic [31:0] SEED_MIX      = 32'hD05FE123;
  localparam logic [31:0] SEED_STEP     = 32'h9E3779B9;
  localparam logic [31:0] SEED_ZERO_SUB = 32'hA5A5A5A5;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITEN_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION_KEY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_INDEX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_STRIDE = 3'd4;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_PAIR   = 2'd2;
  localparam logic [1:0] MODE_GROUP  = 2'd3;

  localparam logic [1:0] MEMBERS_THREE = 2'd3;

  localparam logic [2:0] COUNT_ONE   = 3'd1;
  localparam logic [2:0] COUNT_TWO   = 3'd2;
  localparam logic [2:0] COUNT_THREE = 3'd3;
  localparam logic [2:0] COUNT_FOUR  = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    logic        first;
    logic [1:0]  mode;
    logic [1:0]  members;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  members;
    logic [31:0] seed1;
    logic [31:0] seed2;
    logic [31:0] seed3;
    logic        settled;
  } cfg_t;

  function automatic logic [31:0] xs32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  function automatic logic [31:0] crc_feed8(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_REFL_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] seed_finish(input logic [31:0] session,
                                              input logic [31:0] prod);
    logic [31:0] s;
    s = session ^ prod ^ SEED_MIX;
    return (s == 32'd0) ? SEED_ZERO_SUB : s;
  endfunction

endpackage

@@ sv/wpc_if.sv @@
interface wpc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source(output valid, data_word, byte_count, last_word, input ready);
  modport sink(input valid, data_word, byte_count, last_word, output ready);
endinterface

interface wpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] whitened_word;
  logic [2:0]  out_byte_count;
  logic        out_last;
  logic [31:0] frame_crc;

  modport source(output valid, whitened_word, out_byte_count, out_last, frame_crc,
                 input ready);
  modport sink(input valid, whitened_word, out_byte_count, out_last, frame_crc,
               output ready);
endinterface

@@ sv/whitened_payload_crc.sv @@
// Payload whitening with CRC-32.
// data_in: one payload word per transfer (valid/ready), bytes little-endian,
//   byte_count 1..4 valid bytes, last_word on the final word of a payload.
// data_out: one whitened word per input word, in order, with its byte count,
//   a last flag and, on the last word, the CRC-32 of all whitened bytes.
// cfg_we/cfg_index/cfg_data: register writes. Write only while no word is in
//   flight. After each write data_in.ready stays low while the stream seeds
//   are recomputed (index add, constant multiply, mix).
// Throughput: one word per cycle while data_out is not stalled; the stream
//   step and the 4-byte CRC update finish in the single back-end stage.
// A 4-entry queue sits between input and back end, and the back end holds
//   its result in an output register: when data_out stalls, the queue keeps
//   taking words until it is full, then data_in.ready drops.
// Reset: registers return to their defaults, queue and output empty, no
//   frame open; data_in.ready rises once the seeds are recomputed.
module whitened_payload_crc
  import wpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  wpc_in_if.sink               data_in,
  wpc_out_if.source            data_out
);

  cfg_t  cfg;
  item_t head;
  logic  not_empty;
  logic  pop;

  wpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .data_in   (data_in),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  wpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .data_out  (data_out)
  );

endmodule

@@ sv/wpc_cfg.sv @@
module wpc_cfg
  import wpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  logic [1:0]  whiten_mode;
  logic [31:0] session_key;
  logic [31:0] frame_index;
  logic [1:0]  member_count;
  logic [31:0] member_stride;
  logic [1:0]  settle_cnt;

  logic [31:0] stride_eff;
  logic [31:0] idx0, idx1, idx2;
  logic [31:0] prod0, prod1, prod2;
  logic [31:0] seed1, seed2, seed3;

  always_ff @(posedge clk) begin
    if (rst) begin
      whiten_mode   <= MODE_SINGLE;
      session_key   <= 32'd0;
      frame_index   <= 32'd0;
      member_count  <= 2'd1;
      member_stride <= 32'd1;
      settle_cnt    <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle_cnt <= SETTLE_CYCLES;
        case (cfg_index)
          REG_WHITEN_MODE:   whiten_mode   <= cfg_data[1:0];
          REG_SESSION_KEY:   session_key   <= cfg_data;
          REG_FRAME_INDEX:   frame_index   <= cfg_data;
          REG_MEMBER_COUNT:  member_count  <= cfg_data[1:0];
          REG_MEMBER_STRIDE: member_stride <= cfg_data;
          default: ;
        endcase
      end else if (settle_cnt != 2'd0) begin
        settle_cnt <= settle_cnt - 2'd1;
      end
    end
  end

  assign stride_eff = (member_stride == 32'd0) ? 32'd1 : member_stride;

  // seed pipeline: member indexes, products, finished seeds
  always_ff @(posedge clk) begin
    idx0  <= frame_index;
    idx1  <= frame_index + stride_eff;
    idx2  <= (whiten_mode == MODE_PAIR) ? frame_index + 32'd1
                                        : frame_index + (stride_eff << 1);
    prod0 <= idx0 * SEED_STEP;
    prod1 <= idx1 * SEED_STEP;
    prod2 <= idx2 * SEED_STEP;
    seed1 <= seed_finish(session_key, prod0);
    seed2 <= (whiten_mode == MODE_GROUP && member_count[1])
             ? seed_finish(session_key, prod1) : 32'd0;
    seed3 <= (whiten_mode == MODE_PAIR ||
              (whiten_mode == MODE_GROUP && member_count == MEMBERS_THREE))
             ? seed_finish(session_key, prod2) : 32'd0;
  end

  assign cfg.mode    = whiten_mode;
  assign cfg.members = member_count;
  assign cfg.seed1   = seed1;
  assign cfg.seed2   = seed2;
  assign cfg.seed3   = seed3;
  assign cfg.settled = (settle_cnt == 2'd0);

endmodule

@@ sv/wpc_front.sv @@
module wpc_front
  import wpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  wpc_in_if.sink    data_in,
  input  logic      pop,
  output item_t     head,
  output logic      not_empty
);

  item_t               queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                in_frame;
  logic                push;
  item_t               entry;

  assign data_in.ready = (fill != (QUEUE_AW+1)'(QUEUE_DEPTH)) && cfg.settled;
  assign push          = data_in.valid && data_in.ready;
  assign not_empty     = (fill != '0);
  assign head          = queue[rd_ptr];

  always_comb begin
    entry.word = data_in.data_word;
    case (data_in.byte_count)
      3'd0:        entry.count = COUNT_ONE;
      COUNT_ONE:   entry.count = COUNT_ONE;
      COUNT_TWO:   entry.count = COUNT_TWO;
      COUNT_THREE: entry.count = COUNT_THREE;
      default:     entry.count = COUNT_FOUR;
    endcase
    entry.last    = data_in.last_word;
    entry.first   = !in_frame;
    entry.mode    = cfg.mode;
    entry.members = cfg.members;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      in_frame <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr   <= wr_ptr + QUEUE_AW'(1);
        in_frame <= !data_in.last_word;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (QUEUE_AW+1)'(1);
        2'b01:   fill <= fill - (QUEUE_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/wpc_back.sv @@
module wpc_back
  import wpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  item_t     head,
  input  logic      not_empty,
  output logic      pop,
  wpc_out_if.source data_out
);

  logic [31:0] s1, s2, s3, crc;
  logic [31:0] base1, base2, base3, crc_base;
  logic [31:0] n1, n2, n3, key, mixed, res;
  logic [31:0] c1, c2, c3, c4, crc_new;
  logic        use2, use3;

  assign pop = not_empty && (!data_out.valid || data_out.ready);

  always_comb begin
    base1    = head.first ? cfg.seed1 : s1;
    base2    = head.first ? cfg.seed2 : s2;
    base3    = head.first ? cfg.seed3 : s3;
    crc_base = head.first ? CRC_ALL_ONES : crc;

    use2 = (head.mode == MODE_GROUP) && head.members[1];
    use3 = (head.mode == MODE_PAIR) ||
           ((head.mode == MODE_GROUP) && (head.members == MEMBERS_THREE));

    n1 = (head.mode != MODE_NONE) ? xs32(base1) : base1;
    n2 = use2 ? xs32(base2) : base2;
    n3 = use3 ? xs32(base3) : base3;

    case (head.mode)
      MODE_NONE:   key = 32'd0;
      MODE_SINGLE: key = n1;
      MODE_PAIR:   key = n1 ^ n3;
      default:     key = n1 ^ (use2 ? n2 : 32'd0) ^ (use3 ? n3 : 32'd0);
    endcase

    mixed = head.word ^ key;
    case (head.count)
      COUNT_ONE:   res = {24'd0, mixed[7:0]};
      COUNT_TWO:   res = {16'd0, mixed[15:0]};
      COUNT_THREE: res = {8'd0, mixed[23:0]};
      default:     res = mixed;
    endcase

    c1 = crc_feed8(crc_base, res[7:0]);
    c2 = crc_feed8(c1, res[15:8]);
    c3 = crc_feed8(c2, res[23:16]);
    c4 = crc_feed8(c3, res[31:24]);
    case (head.count)
      COUNT_ONE:   crc_new = c1;
      COUNT_TWO:   crc_new = c2;
      COUNT_THREE: crc_new = c3;
      default:     crc_new = c4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1  <= n1;
      s2  <= n2;
      s3  <= n3;
      crc <= head.last ? CRC_ALL_ONES : crc_new;
      data_out.whitened_word  <= res;
      data_out.out_byte_count <= head.count;
      data_out.out_last       <= head.last;
      data_out.frame_crc      <= head.last ? (crc_new ^ CRC_ALL_ONES) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_out.valid <= 1'b0;
    end else if (pop) begin
      data_out.valid <= 1'b1;
    end else if (data_out.ready) begin
      data_out.valid <= 1'b0;
    end
  end

endmodule

@@ sv/wpc_checker.sv @@
module wpc_checker
  import wpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] whitened_word,
  input logic [2:0]  out_byte_count,
  input logic        out_last,
  input logic [31:0] frame_crc
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(whitened_word) &&
      $stable(out_byte_count) && $stable(out_last) && $stable(frame_crc))
    else $error("output transfer changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_crc_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> frame_crc == 32'd0)
    else $error("crc on a word that is not last");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte_count == COUNT_ONE || out_byte_count == COUNT_TWO ||
      out_byte_count == COUNT_THREE || out_byte_count == COUNT_FOUR)
    else $error("byte count out of range");

  a_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte_count != COUNT_FOUR |-> whitened_word[31:24] == 8'd0 &&
      (out_byte_count == COUNT_THREE || whitened_word[23:16] == 8'd0) &&
      (out_byte_count != COUNT_ONE || whitened_word[15:8] == 8'd0))
    else $error("bytes beyond the count not zero");

endmodule

bind whitened_payload_crc wpc_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (data_out.valid),
  .out_ready      (data_out.ready),
  .whitened_word  (data_out.whitened_word),
  .out_byte_count (data_out.out_byte_count),
  .out_last       (data_out.out_last),
  .frame_crc      (data_out.frame_crc)
);

@@ tb/testbench.sv @@
module testbench;
  import wpc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int WORD_TARGET = 2020;
  localparam logic [1:0] MEMBERS_TWO = 2'd2;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    logic [31:0] crc;
  } word_result_t;

  class whitening_scoreboard;
    logic [1:0]   mode;
    logic [31:0]  session;
    logic [31:0]  first_index;
    logic [1:0]   members;
    logic [31:0]  stride;
    logic [31:0]  lane1, lane2, lane3;
    logic [31:0]  crc_acc;
    bit           in_frame;
    word_result_t awaited[$];
    int           words, frames, results, errors;

    function new();
      mode = MODE_SINGLE;
      session = '0;
      first_index = '0;
      members = 2'd1;
      stride = 32'd1;
      lane1 = '0;
      lane2 = '0;
      lane3 = '0;
      crc_acc = CRC_ALL_ONES;
      in_frame = 1'b0;
      words = 0;
      frames = 0;
      results = 0;
      errors = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
      case (idx)
        REG_WHITEN_MODE:   mode = val[1:0];
        REG_SESSION_KEY:   session = val;
        REG_FRAME_INDEX:   first_index = val;
        REG_MEMBER_COUNT:  members = val[1:0];
        REG_MEMBER_STRIDE: stride = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] xorshift_step(input logic [31:0] x);
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      return x ^ (x << 5);
    endfunction

    function logic [31:0] seed_for(input logic [31:0] idx);
      logic [31:0] prod;
      logic [31:0] s;
      prod = idx * SEED_STEP;
      s = session ^ prod ^ SEED_MIX;
      return (s != 32'd0) ? s : SEED_ZERO_SUB;
    endfunction

    function void crc_absorb(input logic [31:0] data, input int nbytes);
      logic fb;
      for (int b = 0; b < 8 * nbytes; b++) begin
        fb = crc_acc[0] ^ data[b];
        crc_acc = crc_acc >> 1;
        if (fb) crc_acc = crc_acc ^ CRC_REFL_POLY;
      end
    endfunction

    function void note_word(input logic [31:0] data, input logic [2:0] count_in,
                            input logic last);
      logic [31:0]  key;
      logic [31:0]  span;
      logic [31:0]  masked;
      logic [2:0]   count;
      word_result_t r;
      count = count_in;
      if (count == 3'd0) count = COUNT_ONE;
      if (count > COUNT_FOUR) count = COUNT_FOUR;
      if (!in_frame) begin
        span = (stride == 32'd0) ? 32'd1 : stride;
        lane1 = seed_for(first_index);
        lane2 = '0;
        lane3 = '0;
        if (mode == MODE_GROUP) begin
          if (members >= MEMBERS_TWO) lane2 = seed_for(first_index + span);
          if (members == MEMBERS_THREE) lane3 = seed_for(first_index + (span << 1));
        end else if (mode == MODE_PAIR) begin
          lane3 = seed_for(first_index + 32'd1);
        end
        crc_acc = CRC_ALL_ONES;
        in_frame = 1'b1;
      end
      key = '0;
      case (mode)
        MODE_GROUP: begin
          lane1 = xorshift_step(lane1);
          key = lane1;
          if (members >= MEMBERS_TWO) begin
            lane2 = xorshift_step(lane2);
            key = key ^ lane2;
          end
          if (members == MEMBERS_THREE) begin
            lane3 = xorshift_step(lane3);
            key = key ^ lane3;
          end
        end
        MODE_PAIR: begin
          lane1 = xorshift_step(lane1);
          lane3 = xorshift_step(lane3);
          key = lane1 ^ lane3;
        end
        MODE_SINGLE: begin
          lane1 = xorshift_step(lane1);
          key = lane1;
        end
        default: ;
      endcase
      masked = data ^ key;
      if (count < COUNT_FOUR) masked = masked & ((32'd1 << (8 * count)) - 32'd1);
      crc_absorb(masked, count);
      r.word = masked;
      r.count = count;
      r.last = last;
      r.crc = last ? ~crc_acc : '0;
      if (last) begin
        crc_acc = CRC_ALL_ONES;
        in_frame = 1'b0;
        frames++;
      end
      words++;
      awaited.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(input word_result_t got);
      word_result_t want;
      results++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word %h count %0d last %0b crc %h",
                 $time, got.word, got.count, got.last, got.crc);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("whitened_word", want.word, got.word);
      compare_field("out_byte_count", 32'(want.count), 32'(got.count));
      compare_field("out_last", 32'(want.last), 32'(got.last));
      compare_field("frame_crc", want.crc, got.crc);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  bit                   steady;
  int                   cycles;
  int                   settings_applied;
  whitening_scoreboard  sb;

  wpc_in_if  in_ch();
  wpc_out_if out_ch();

  whitened_payload_crc dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .data_in(in_ch),
    .data_out(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom_range(0, 4);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin : out_pacing
    int stall;
    if (rst || steady) begin
      out_ch.ready <= 1'b1;
      stall = 0;
    end else if (stall > 0) begin
      stall = stall - 1;
    end else if (out_ch.ready) begin
      stall = idle_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall = stall - 1;
      end else begin
        stall = $urandom_range(0, 6);
      end
    end else begin
      out_ch.ready <= 1'b1;
      stall = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin : observe
    word_result_t seen;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.data_word, in_ch.byte_count, in_ch.last_word);
      if (out_ch.valid && out_ch.ready) begin
        seen.word = out_ch.whitened_word;
        seen.count = out_ch.out_byte_count;
        seen.last = out_ch.out_last;
        seen.crc = out_ch.frame_crc;
        sb.check_word(seen);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.awaited.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic apply_settings(input logic [1:0] mode, input logic [31:0] key,
                                input logic [31:0] idx, input logic [1:0] members,
                                input logic [31:0] stride);
    write_reg(REG_WHITEN_MODE, ($urandom() & ~32'd3) | 32'(mode));
    write_reg(REG_SESSION_KEY, key);
    write_reg(REG_FRAME_INDEX, idx);
    write_reg(REG_MEMBER_COUNT, ($urandom() & ~32'd3) | 32'(members));
    write_reg(REG_MEMBER_STRIDE, stride);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                           input logic last);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= data;
    in_ch.byte_count <= count;
    in_ch.last_word <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(input int len, input bit close);
    logic [2:0] count;
    bit         is_last;
    for (int i = 0; i < len; i++) begin
      is_last = close && (i == len - 1);
      count = is_last ? 3'($urandom_range(1, 4)) : COUNT_FOUR;
      if ($urandom_range(0, 9) == 0) count = 3'($urandom_range(0, 7));
      send_word($urandom(), count, is_last);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  initial begin
    int phase_end;
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_WHITEN_MODE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_word <= '0;
    in_ch.byte_count <= COUNT_FOUR;
    in_ch.last_word <= 1'b0;
    steady <= 1'b0;
    settings_applied = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_word(32'h00000000, COUNT_FOUR, 1'b0);
    send_word(32'hFFFFFFFF, COUNT_FOUR, 1'b0);
    send_word($urandom(), 3'd0, 1'b0);
    send_word($urandom(), 3'd5, 1'b0);
    send_word($urandom(), 3'd6, 1'b0);
    send_word($urandom(), 3'd7, 1'b1);
    send_word($urandom(), COUNT_ONE, 1'b1);
    send_word($urandom(), COUNT_TWO, 1'b1);
    send_word($urandom(), COUNT_THREE, 1'b1);
    settle();

    apply_settings(MODE_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, MEMBERS_THREE, 32'd0);
    send_word(32'hFFFFFFFF, COUNT_FOUR, 1'b0);
    send_word(32'h00000000, COUNT_FOUR, 1'b0);
    settle();
    // frame still open: seeds hold, mode switches on the next word
    apply_settings(MODE_GROUP, 32'd0, 32'hFFFFFFFF, MEMBERS_THREE, 32'hFFFFFFFF);
    send_word($urandom(), COUNT_FOUR, 1'b0);
    send_word($urandom(), COUNT_TWO, 1'b1);
    settle();

    apply_settings(MODE_GROUP, $urandom(), $urandom(), MEMBERS_THREE, 32'd0);
    send_frame(2, 1'b1);
    settle();
    apply_settings(MODE_PAIR, $urandom(), 32'hFFFFFFFF, 2'd1, 32'd1);
    send_frame(2, 1'b1);
    settle();
    for (int m = 0; m < 3; m++) begin
      apply_settings(MODE_GROUP, $urandom(), $urandom(), 2'(m), $urandom());
      send_frame(1, 1'b1);
      settle();
    end
    // seed collapses to zero and takes the substitute value
    apply_settings(MODE_SINGLE, SEED_MIX, 32'd0, 2'd1, 32'd1);
    send_frame(2, 1'b1);
    settle();

    while (sb.words < WORD_TARGET) begin
      apply_settings(2'($urandom_range(0, 3)), pick_word(), pick_word(),
                     2'($urandom_range(0, 3)), pick_word());
      steady <= ($urandom_range(0, 4) == 0);
      phase_end = sb.words + $urandom_range(40, 200);
      while (sb.words < phase_end) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(1, 12),
                   $urandom_range(0, 14) != 0);
      end
      settle();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d words in %0d closed frames under %0d register settings",
             sb.words, sb.frames, settings_applied);
    $display("all whitening modes, member counts 0-3, clamped byte counts; %0d results compared",
             sb.results);
    if (sb.awaited.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.awaited.size());
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/wpc_pkg.sv
sv/wpc_if.sv
sv/wpc_cfg.sv
sv/wpc_front.sv
sv/wpc_back.sv
sv/whitened_payload_crc.sv
sv/wpc_checker.sv
tb/testbench.sv
